/* rtl/core/char_lcd_nibble_write_sequencer_core_assert.svh */
// Assertion macros shared by the LCD write sequencer modules.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LCDNWS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: implication check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define LCDNWS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/core/lcdnws_pkg.sv */
// Types, constants and the Cyrillic code table of the LCD write sequencer.
package lcdnws_pkg;

  localparam int unsigned DELAY_W = 24;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd10000;

  localparam logic [7:0] XLATE_FLOOR = 8'hA0;
  localparam logic [7:0] CYR_BASE    = 8'hC0;
  localparam logic [7:0] CYR_YO_UP   = 8'hA8;
  localparam logic [7:0] CYR_YO_LO   = 8'hB8;
  localparam logic [7:0] LCD_YO      = 8'hA2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_INIT  = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       rs;
    logic [7:0] code;
  } entry_t;

  localparam logic [7:0] CYR_TABLE [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // Windows-1251 Cyrillic to display character code.
  function automatic logic [7:0] xlate(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CYR_BASE) begin
      r = CYR_TABLE[b[5:0]];
    end else if (b == CYR_YO_UP || b == CYR_YO_LO) begin
      r = LCD_YO;
    end
    return r;
  endfunction

endpackage

/* rtl/core/char_lcd_nibble_write_sequencer_core.sv */
// Top level of the four-bit character LCD write sequencer.
//
//   channel   dir  handshake                 payload
//   request   in   in_valid_i / in_ready_o   command_i, value_byte_i, is_data_i
//   pin state out  out_valid_o / out_ready_i reg_select_o, nibble_o, enable_o,
//                                            hold_units_o, last_o
//   delay     in   delay_we_i                delay_cycles_i
//
// A byte write gives 4 pin states, init gives 7 (first one held 3 units).
// Each state is loaded, handed over once out_ready_i is high, then held in
// the sequencer for hold_units delay units.
// Requests queue up (QUEUE_DEPTH deep) while the sequencer holds pins.
// Reset is asynchronous, active low; delay_cycles resets to 10000.
module char_lcd_nibble_write_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            delay_we_i,
  input  logic [lcdnws_pkg::DELAY_W-1:0]  delay_cycles_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [7:0]                      value_byte_i,
  input  logic                            is_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            reg_select_o,
  output logic [3:0]                      nibble_o,
  output logic                            enable_o,
  output logic [1:0]                      hold_units_o,
  output logic                            last_o
);
  import lcdnws_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_item, pop_item;

  lcdnws_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .value_byte_i (value_byte_i),
    .is_data_i    (is_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  lcdnws_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  lcdnws_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .delay_we_i     (delay_we_i),
    .delay_cycles_i (delay_cycles_i),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reg_select_o   (reg_select_o),
    .nibble_o       (nibble_o),
    .enable_o       (enable_o),
    .hold_units_o   (hold_units_o),
    .last_o         (last_o)
  );

endmodule

/* rtl/core/lcdnws_front.sv */
// Front end: accepts requests, translates data bytes, pushes queue entries.
module lcdnws_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [7:0]          value_byte_i,
  input  logic                is_data_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output lcdnws_pkg::entry_t  push_item_o
);
  import lcdnws_pkg::*;

  logic [7:0] code;

  always_comb begin
    code = value_byte_i;
    if (is_data_i && value_byte_i > XLATE_FLOOR) begin
      code = xlate(value_byte_i);
    end
  end

  always_comb begin
    if (command_i) begin
      push_item_o.op   = OP_INIT;
      push_item_o.rs   = 1'b0;
      push_item_o.code = '0;
    end else begin
      push_item_o.op   = OP_WRITE;
      push_item_o.rs   = is_data_i;
      push_item_o.code = code;
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

/* rtl/core/lcdnws_fifo.sv */
// Short request queue between front end and pin sequencer.
module lcdnws_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  lcdnws_pkg::entry_t  push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output lcdnws_pkg::entry_t  pop_item_o
);
  import lcdnws_pkg::*;
  `include "char_lcd_nibble_write_sequencer_core_assert.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `LCDNWS_ASSERT_IMP(a_cnt_bound, 1'b1, count_q <= CNT_W'(DEPTH))
  `LCDNWS_ASSERT_NXT(a_cnt_up, push && !pop, count_q == $past(count_q) + 1'b1)
  `LCDNWS_ASSERT_NXT(a_cnt_dn, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

/* rtl/core/lcdnws_back.sv */
// Pin sequencer: expands queue entries into timed LCD pin states.
module lcdnws_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            delay_we_i,
  input  logic [lcdnws_pkg::DELAY_W-1:0]  delay_cycles_i,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  lcdnws_pkg::entry_t              pop_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            reg_select_o,
  output logic [3:0]                      nibble_o,
  output logic                            enable_o,
  output logic [1:0]                      hold_units_o,
  output logic                            last_o
);
  import lcdnws_pkg::*;
  `include "char_lcd_nibble_write_sequencer_core_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHOW,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       en;
    logic [1:0] hold;
    logic       last;
  } pin_t;

  localparam logic [2:0] WRITE_LAST = 3'd3;
  localparam logic [2:0] INIT_LAST  = 3'd6;
  localparam logic [2:0] INIT_FN8   = 3'd5;
  localparam logic [3:0] NIB_FN     = 4'h2;
  localparam logic [3:0] NIB_4BIT   = 4'h8;
  localparam logic [1:0] HOLD_ONE   = 2'd1;
  localparam logic [1:0] HOLD_IDLE  = 2'd3;

  state_e             st_q;
  entry_t             ent_q;
  logic [2:0]         step_q;
  logic [1:0]         unit_q;
  logic [DELAY_W-1:0] tick_q, delay_q, reload;
  logic               out_valid_q;
  pin_t               out_q, pin;

  assign reload = (delay_q == '0) ? DELAY_W'(1) : delay_q;

  always_comb begin
    pin.rs = ent_q.rs;
    case (ent_q.op)
      OP_INIT: begin
        pin.rs   = 1'b0;
        pin.last = (step_q == INIT_LAST);
        if (step_q == '0) begin
          pin.nib  = '0;
          pin.en   = 1'b0;
          pin.hold = HOLD_IDLE;
        end else begin
          pin.nib  = (step_q < INIT_FN8) ? NIB_FN : NIB_4BIT;
          pin.en   = step_q[0];
          pin.hold = HOLD_ONE;
        end
      end
      default: begin
        pin.nib  = step_q[1] ? ent_q.code[3:0] : ent_q.code[7:4];
        pin.en   = ~step_q[0];
        pin.hold = HOLD_ONE;
        pin.last = (step_q == WRITE_LAST);
      end
    endcase
  end

  assign pop_ready_o = (st_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ent_q       <= '0;
      step_q      <= '0;
      unit_q      <= '0;
      tick_q      <= '0;
      delay_q     <= DELAY_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (delay_we_i) begin
        delay_q <= delay_cycles_i;
      end
      case (st_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            ent_q  <= pop_item_i;
            step_q <= '0;
            st_q   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          out_q       <= pin;
          out_valid_q <= 1'b1;
          st_q        <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            tick_q      <= reload;
            unit_q      <= out_q.hold;
            st_q        <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (tick_q == DELAY_W'(1)) begin
            if (unit_q == 2'd1) begin
              if (out_q.last) begin
                st_q <= ST_IDLE;
              end else begin
                step_q <= step_q + 1'b1;
                st_q   <= ST_LOAD;
              end
            end else begin
              unit_q <= unit_q - 1'b1;
              tick_q <= reload;
            end
          end else begin
            tick_q <= tick_q - 1'b1;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reg_select_o = out_q.rs;
  assign nibble_o     = out_q.nib;
  assign enable_o     = out_q.en;
  assign hold_units_o = out_q.hold;
  assign last_o       = out_q.last;

  `LCDNWS_ASSERT_IMP(a_valid_show, out_valid_q, st_q == ST_SHOW)
  `LCDNWS_ASSERT_IMP(a_wait_live, st_q == ST_WAIT, unit_q != '0 && tick_q != '0)
  `LCDNWS_ASSERT_NXT(a_take_wait, st_q == ST_SHOW && out_ready_i,
                     st_q == ST_WAIT && !out_valid_q)

endmodule
